// ===== design/les_pkg.sv =====
package les_pkg;

  // Coordinate width of the points and of the query words.
  localparam int CoordWidth  = 16;
  localparam int CoefAbWidth = CoordWidth + 1;
  localparam int CoefCWidth  = 2 * CoordWidth + 1;
  // Magnitudes handled by the gcd and divide unit.
  localparam int MagWidth    = CoefCWidth;
  localparam int ShiftWidth  = $clog2(MagWidth + 1);
  localparam int ProdWidth   = CoefAbWidth + CoordWidth;
  // Holds a*x + b*y + c without wrapping.
  localparam int AccWidth    = 2 * CoordWidth + 4;

  typedef enum logic [1:0] {
    CMD_DEFINE,
    CMD_MOVE,
    CMD_POINT,
    CMD_SEGMENT
  } les_cmd_e;

  typedef enum logic {
    OP_GCD,
    OP_DIV
  } les_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD1,
    ST_PROD2,
    ST_CVAL,
    ST_GCD_AB,
    ST_GCD_C,
    ST_DIV_A,
    ST_DIV_B,
    ST_DIV_C,
    ST_SIDE_AX,
    ST_SIDE_BY,
    ST_SIDE_SUM,
    ST_SIDE_EVAL,
    ST_OUT
  } les_state_e;

  typedef struct packed {
    logic    start;
    les_op_e op;
  } les_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } les_stat_t;

endpackage

// ===== design/les_mul.sv =====
module les_mul import les_pkg::*; (
  input  logic                        clk_i,
  input  logic signed [CoefAbWidth-1:0] mul_a_i,
  input  logic signed [CoordWidth-1:0]  mul_b_i,
  output logic signed [ProdWidth-1:0]   prod_o
);

  logic signed [ProdWidth-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_i * mul_b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== design/les_divgcd.sv =====
module les_divgcd import les_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  les_req_t            req_i,
  input  logic [MagWidth-1:0] opa_i,
  input  logic [MagWidth-1:0] opb_i,
  output les_stat_t           stat_o,
  output logic [MagWidth-1:0] res_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  les_op_e               op_q, op_d;
  logic [MagWidth-1:0]   u_q, u_d;
  logic [MagWidth-1:0]   v_q, v_d;
  logic [MagWidth-1:0]   rem_q, rem_d;
  logic [MagWidth-1:0]   res_q, res_d;
  logic [ShiftWidth-1:0] k_q, k_d;
  logic [ShiftWidth-1:0] cnt_q, cnt_d;

  logic [MagWidth:0]     sub_x;
  logic [MagWidth:0]     sub_y;
  logic [MagWidth+1:0]   diff;
  logic                  diff_neg;
  logic [MagWidth-1:0]   gcd_base;
  logic [MagWidth-1:0]   quo_next;

  // The one subtractor serves both the gcd compare and the divide trial.
  always_comb begin
    sub_y    = {1'b0, v_q};
    sub_x    = (op_q == OP_DIV) ? {rem_q, u_q[MagWidth-1]} : {1'b0, u_q};
    diff     = {1'b0, sub_x} - {1'b0, sub_y};
    diff_neg = diff[MagWidth+1];
    gcd_base = (u_q == '0) ? v_q : u_q;
    quo_next = {u_q[MagWidth-2:0], ~diff_neg};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    u_d    = u_q;
    v_d    = v_q;
    rem_d  = rem_q;
    res_d  = res_q;
    k_d    = k_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      op_d   = req_i.op;
      u_d    = opa_i;
      v_d    = opb_i;
      rem_d  = '0;
      k_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      unique case (op_q)
        OP_GCD: begin
          // Binary gcd: strip common factors of two, then subtract odd values.
          priority if (u_q == '0 || v_q == '0) begin
            res_d  = gcd_base << k_q;
            busy_d = 1'b0;
            done_d = 1'b1;
          end else if (!u_q[0] && !v_q[0]) begin
            u_d = u_q >> 1;
            v_d = v_q >> 1;
            k_d = k_q + 1'b1;
          end else if (!u_q[0]) begin
            u_d = u_q >> 1;
          end else if (!v_q[0]) begin
            v_d = v_q >> 1;
          end else if (!diff_neg) begin
            u_d = diff[MagWidth-1:0];
          end else begin
            u_d = v_q;
            v_d = u_q;
          end
        end
        OP_DIV: begin
          // Restoring division; the quotient shifts into u as the dividend leaves.
          u_d   = quo_next;
          rem_d = diff_neg ? sub_x[MagWidth-1:0] : diff[MagWidth-1:0];
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == ShiftWidth'(MagWidth - 1)) begin
            res_d  = quo_next;
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_GCD;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    rem_q <= rem_d;
    res_q <= res_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = res_q;

endmodule

// ===== design/line_equation_side_test_unit.sv =====
// Keeps one line through two stored points as a*x + b*y + c = 0, with the three
// coefficients reduced by their nonnegative gcd; every word returned carries them.
// Items are taken one at a time, and the finished word waits in an output register
// so the next item can start meanwhile. A define or move runs two products on the
// shared multiplier, then the shared gcd/divide unit runs a binary gcd of |a| and
// |b|, a second gcd with |c| (one shift, subtract or swap per cycle), and three
// restoring divisions, each unit operation started by a request and closed by its
// done flag. Equal defining points skip the unit, give zero coefficients and set
// the degenerate flag.
module line_equation_side_test_unit import les_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic signed [CoordWidth-1:0] x_first_i,
  input  logic signed [CoordWidth-1:0] y_first_i,
  input  logic signed [CoordWidth-1:0] x_second_i,
  input  logic signed [CoordWidth-1:0] y_second_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         on_line_o,
  output logic                         crosses_o,
  output logic signed [CoefAbWidth-1:0] coef_a_o,
  output logic signed [CoefAbWidth-1:0] coef_b_o,
  output logic signed [CoefCWidth-1:0]  coef_c_o,
  output logic                         degenerate_o
);

  function automatic logic [CoordWidth-1:0] sat_coord(input logic [CoordWidth:0] v);
    logic [CoordWidth-1:0] lim;
    lim = {v[CoordWidth], {(CoordWidth-1){~v[CoordWidth]}}};
    return (v[CoordWidth] != v[CoordWidth-1]) ? lim : v[CoordWidth-1:0];
  endfunction

  function automatic logic [MagWidth-1:0] mag_ab(input logic [CoefAbWidth-1:0] v);
    logic [CoefAbWidth-1:0] m;
    m = v[CoefAbWidth-1] ? (~v + 1'b1) : v;
    return {{(MagWidth-CoefAbWidth){1'b0}}, m};
  endfunction

  function automatic logic [MagWidth-1:0] mag_c(input logic [CoefCWidth-1:0] v);
    return v[CoefCWidth-1] ? (~v + 1'b1) : v;
  endfunction

  les_state_e state_q, state_d;
  les_cmd_e   cmd_q, cmd_d;
  les_cmd_e   in_cmd;
  logic       in_accept;

  logic [CoordWidth-1:0]  xf_q, xf_d, yf_q, yf_d, xs_q, xs_d, ys_q, ys_d;
  logic [CoordWidth-1:0]  p1x_q, p1x_d, p1y_q, p1y_d, p2x_q, p2x_d, p2y_q, p2y_d;
  logic [CoefAbWidth-1:0] a_raw_q, a_raw_d, b_raw_q, b_raw_d;
  logic [CoefCWidth-1:0]  c_raw_q, c_raw_d;
  logic [MagWidth-1:0]    g_q, g_d;
  logic [CoefAbWidth-1:0] eq_a_q, eq_a_d, eq_b_q, eq_b_d;
  logic [CoefCWidth-1:0]  eq_c_q, eq_c_d;
  logic                   degen_q, degen_d;
  logic [AccWidth-1:0]    acc_q, acc_d;
  logic                   sel_q, sel_d;
  logic                   s0_zero_q, s0_zero_d, s0_neg_q, s0_neg_d;
  logic                   res_on_q, res_on_d, res_cross_q, res_cross_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_on_q, out_on_d, out_cross_q, out_cross_d;
  logic [CoefAbWidth-1:0] out_a_q, out_a_d, out_b_q, out_b_d;
  logic [CoefCWidth-1:0]  out_c_q, out_c_d;
  logic                   out_degen_q, out_degen_d;

  logic signed [CoefAbWidth-1:0] mul_a;
  logic signed [CoordWidth-1:0]  mul_b;
  logic signed [ProdWidth-1:0]   prod;
  logic [AccWidth-1:0]           prod_ext;
  logic [AccWidth-1:0]           c_diff;
  logic [CoordWidth-1:0]         px, py;
  logic                          acc_zero, acc_neg;
  logic                          out_free;

  les_req_t            unit_req;
  les_stat_t           unit_stat;
  logic [MagWidth-1:0] unit_opa, unit_opb, unit_res;
  logic                unit_go;

  les_mul u_mul (
    .clk_i   (clk_i),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .prod_o  (prod)
  );

  les_divgcd u_divgcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .opa_i  (unit_opa),
    .opb_i  (unit_opb),
    .stat_o (unit_stat),
    .res_o  (unit_res)
  );

  assign in_cmd     = les_cmd_e'(command_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign prod_ext   = {{(AccWidth-ProdWidth){prod[ProdWidth-1]}}, prod};
  assign c_diff     = acc_q - prod_ext;
  assign px         = sel_q ? xs_q : xf_q;
  assign py         = sel_q ? ys_q : yf_q;
  assign acc_zero   = (acc_q == '0);
  assign acc_neg    = acc_q[AccWidth-1];
  // Start the unit once on entry to a unit state; done rises in the same cycle that busy drops.
  assign unit_go    = !unit_stat.busy && !unit_stat.done;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_cmd)
            CMD_DEFINE, CMD_MOVE:  state_d = ST_PROD1;
            CMD_POINT, CMD_SEGMENT: state_d = ST_SIDE_AX;
          endcase
        end
      end
      ST_PROD1: state_d = ST_PROD2;
      ST_PROD2: state_d = ST_CVAL;
      ST_CVAL: begin
        state_d = (a_raw_q == '0 && b_raw_q == '0) ? ST_OUT : ST_GCD_AB;
      end
      ST_GCD_AB: if (unit_stat.done) state_d = ST_GCD_C;
      ST_GCD_C:  if (unit_stat.done) state_d = ST_DIV_A;
      ST_DIV_A:  if (unit_stat.done) state_d = ST_DIV_B;
      ST_DIV_B:  if (unit_stat.done) state_d = ST_DIV_C;
      ST_DIV_C:  if (unit_stat.done) state_d = ST_OUT;
      ST_SIDE_AX:  state_d = ST_SIDE_BY;
      ST_SIDE_BY:  state_d = ST_SIDE_SUM;
      ST_SIDE_SUM: state_d = ST_SIDE_EVAL;
      ST_SIDE_EVAL: begin
        state_d = (cmd_q == CMD_SEGMENT && !sel_q) ? ST_SIDE_AX : ST_OUT;
      end
      ST_OUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath controls and register updates.
  always_comb begin
    cmd_d       = cmd_q;
    xf_d        = xf_q;
    yf_d        = yf_q;
    xs_d        = xs_q;
    ys_d        = ys_q;
    p1x_d       = p1x_q;
    p1y_d       = p1y_q;
    p2x_d       = p2x_q;
    p2y_d       = p2y_q;
    a_raw_d     = a_raw_q;
    b_raw_d     = b_raw_q;
    c_raw_d     = c_raw_q;
    g_d         = g_q;
    eq_a_d      = eq_a_q;
    eq_b_d      = eq_b_q;
    eq_c_d      = eq_c_q;
    degen_d     = degen_q;
    acc_d       = acc_q;
    sel_d       = sel_q;
    s0_zero_d   = s0_zero_q;
    s0_neg_d    = s0_neg_q;
    res_on_d    = res_on_q;
    res_cross_d = res_cross_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_on_d    = out_on_q;
    out_cross_d = out_cross_q;
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    out_c_d     = out_c_q;
    out_degen_d = out_degen_q;
    mul_a       = eq_a_q;
    mul_b       = px;
    unit_req    = '{start: 1'b0, op: OP_GCD};
    unit_opa    = mag_ab(a_raw_q);
    unit_opb    = mag_ab(b_raw_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d       = in_cmd;
          xf_d        = x_first_i;
          yf_d        = y_first_i;
          xs_d        = x_second_i;
          ys_d        = y_second_i;
          sel_d       = 1'b0;
          res_on_d    = 1'b0;
          res_cross_d = 1'b0;
          unique case (in_cmd)
            CMD_DEFINE: begin
              p1x_d = x_first_i;
              p1y_d = y_first_i;
              p2x_d = x_second_i;
              p2y_d = y_second_i;
            end
            CMD_MOVE: begin
              p1x_d = sat_coord({p1x_q[CoordWidth-1], p1x_q} +
                                {x_first_i[CoordWidth-1], x_first_i});
              p1y_d = sat_coord({p1y_q[CoordWidth-1], p1y_q} +
                                {y_first_i[CoordWidth-1], y_first_i});
              p2x_d = sat_coord({p2x_q[CoordWidth-1], p2x_q} +
                                {x_first_i[CoordWidth-1], x_first_i});
              p2y_d = sat_coord({p2y_q[CoordWidth-1], p2y_q} +
                                {y_first_i[CoordWidth-1], y_first_i});
            end
            CMD_POINT, CMD_SEGMENT: begin
            end
          endcase
        end
      end
      ST_PROD1: begin
        mul_a   = {p1x_q[CoordWidth-1], p1x_q};
        mul_b   = p2y_q;
        a_raw_d = {p1y_q[CoordWidth-1], p1y_q} - {p2y_q[CoordWidth-1], p2y_q};
        b_raw_d = {p2x_q[CoordWidth-1], p2x_q} - {p1x_q[CoordWidth-1], p1x_q};
      end
      ST_PROD2: begin
        mul_a = {p2x_q[CoordWidth-1], p2x_q};
        mul_b = p1y_q;
        acc_d = prod_ext;
      end
      ST_CVAL: begin
        c_raw_d = c_diff[CoefCWidth-1:0];
        if (a_raw_q == '0 && b_raw_q == '0) begin
          eq_a_d  = '0;
          eq_b_d  = '0;
          eq_c_d  = '0;
          degen_d = 1'b1;
        end
      end
      ST_GCD_AB: begin
        unit_req = '{start: unit_go, op: OP_GCD};
        if (unit_stat.done) g_d = unit_res;
      end
      ST_GCD_C: begin
        unit_req = '{start: unit_go, op: OP_GCD};
        unit_opa = g_q;
        unit_opb = mag_c(c_raw_q);
        if (unit_stat.done) g_d = unit_res;
      end
      ST_DIV_A: begin
        unit_req = '{start: unit_go, op: OP_DIV};
        unit_opb = g_q;
        if (unit_stat.done) begin
          eq_a_d = a_raw_q[CoefAbWidth-1] ? (~unit_res[CoefAbWidth-1:0] + 1'b1)
                                          : unit_res[CoefAbWidth-1:0];
        end
      end
      ST_DIV_B: begin
        unit_req = '{start: unit_go, op: OP_DIV};
        unit_opa = mag_ab(b_raw_q);
        unit_opb = g_q;
        if (unit_stat.done) begin
          eq_b_d = b_raw_q[CoefAbWidth-1] ? (~unit_res[CoefAbWidth-1:0] + 1'b1)
                                          : unit_res[CoefAbWidth-1:0];
        end
      end
      ST_DIV_C: begin
        unit_req = '{start: unit_go, op: OP_DIV};
        unit_opa = mag_c(c_raw_q);
        unit_opb = g_q;
        if (unit_stat.done) begin
          eq_c_d  = c_raw_q[CoefCWidth-1] ? (~unit_res + 1'b1) : unit_res;
          degen_d = 1'b0;
        end
      end
      ST_SIDE_AX: begin
        mul_a = eq_a_q;
        mul_b = px;
        acc_d = {{(AccWidth-CoefCWidth){eq_c_q[CoefCWidth-1]}}, eq_c_q};
      end
      ST_SIDE_BY: begin
        mul_a = eq_b_q;
        mul_b = py;
        acc_d = acc_q + prod_ext;
      end
      ST_SIDE_SUM: begin
        acc_d = acc_q + prod_ext;
      end
      ST_SIDE_EVAL: begin
        if (cmd_q == CMD_SEGMENT && !sel_q) begin
          s0_zero_d = acc_zero;
          s0_neg_d  = acc_neg;
          sel_d     = 1'b1;
        end else begin
          // A segment crosses when either end touches or the two signs differ.
          res_on_d    = (cmd_q == CMD_POINT) && acc_zero;
          res_cross_d = (cmd_q == CMD_SEGMENT) &&
                        (s0_zero_q || acc_zero || (s0_neg_q != acc_neg));
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_on_d    = res_on_q;
          out_cross_d = res_cross_q;
          out_a_d     = eq_a_q;
          out_b_d     = eq_b_q;
          out_c_d     = eq_c_q;
          out_degen_d = degen_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      p1x_q       <= '0;
      p1y_q       <= '0;
      p2x_q       <= '0;
      p2y_q       <= '0;
      eq_a_q      <= '0;
      eq_b_q      <= '0;
      eq_c_q      <= '0;
      degen_q     <= 1'b1;
      cmd_q       <= CMD_DEFINE;
      sel_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      p1x_q       <= p1x_d;
      p1y_q       <= p1y_d;
      p2x_q       <= p2x_d;
      p2y_q       <= p2y_d;
      eq_a_q      <= eq_a_d;
      eq_b_q      <= eq_b_d;
      eq_c_q      <= eq_c_d;
      degen_q     <= degen_d;
      cmd_q       <= cmd_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xf_q        <= xf_d;
    yf_q        <= yf_d;
    xs_q        <= xs_d;
    ys_q        <= ys_d;
    a_raw_q     <= a_raw_d;
    b_raw_q     <= b_raw_d;
    c_raw_q     <= c_raw_d;
    g_q         <= g_d;
    acc_q       <= acc_d;
    s0_zero_q   <= s0_zero_d;
    s0_neg_q    <= s0_neg_d;
    res_on_q    <= res_on_d;
    res_cross_q <= res_cross_d;
    out_on_q    <= out_on_d;
    out_cross_q <= out_cross_d;
    out_a_q     <= out_a_d;
    out_b_q     <= out_b_d;
    out_c_q     <= out_c_d;
    out_degen_q <= out_degen_d;
  end

  assign out_valid_o  = out_valid_q;
  assign on_line_o    = out_on_q;
  assign crosses_o    = out_cross_q;
  assign coef_a_o     = out_a_q;
  assign coef_b_o     = out_b_q;
  assign coef_c_o     = out_c_q;
  assign degenerate_o = out_degen_q;

endmodule
